[src/cdq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants of the circular deque
// Opcodes, sequencer states, beat payload types and fixed field widths.
// ----------------------------------------------------------------------------
package cdq_pkg;

    // Fixed field widths.
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int CFG_W  = 5;

    // Default ring depth and reset value of the capacity register.
    localparam int              CAPACITY_DEF = 16;
    localparam logic [CFG_W-1:0] CAP_RESET   = 5'd16;

    // Operation codes; the remaining codes act as a refused query.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_QUERY      = 3'd4
    } t_op;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RESP
    } t_state;

    // Command beat.
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    // Response beat.
    typedef struct packed {
        logic                     accepted;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
        logic                     is_empty;
        logic                     is_full;
    } t_rsp;

endpackage

[src/cdq_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_if: valid/ready channels of the circular deque
// Command, response and capacity configuration channels.
// ----------------------------------------------------------------------------

// Command channel.
interface cdq_cmd_if;
    logic          valid;
    logic          ready;
    cdq_pkg::t_cmd payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// Response channel.
interface cdq_rsp_if;
    logic          valid;
    logic          ready;
    cdq_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// Capacity register write channel.
interface cdq_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [cdq_pkg::CFG_W-1:0]   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/cdq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ram: ring entry storage
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module cdq_ram #(
    parameter int DEPTH = cdq_pkg::CAPACITY_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [cdq_pkg::DATA_W-1:0]  i_wr_data,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr_a,
    input  logic [AW-1:0]               i_rd_addr_b,
    output logic [cdq_pkg::DATA_W-1:0]  o_rd_data_a,
    output logic [cdq_pkg::DATA_W-1:0]  o_rd_data_b
);
    import cdq_pkg::*;

    logic [DATA_W-1:0] r_mem [0:DEPTH-1];
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

[src/cdq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ctrl: head/count sequencer of the circular deque
// Applies one operation, writes the ring, then reads front and rear entries.
// ----------------------------------------------------------------------------
module cdq_ctrl #(
    parameter int CAPACITY = cdq_pkg::CAPACITY_DEF,
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    cdq_cmd_if.sink                     i_cmd,
    cdq_rsp_if.source                   o_rsp,
    cdq_cfg_if.sink                     i_cfg,
    output logic                        o_wr_en,
    output logic [AW-1:0]               o_wr_addr,
    output logic [cdq_pkg::DATA_W-1:0]  o_wr_data,
    output logic                        o_rd_en,
    output logic [AW-1:0]               o_rd_addr_a,
    output logic [AW-1:0]               o_rd_addr_b,
    input  logic [cdq_pkg::DATA_W-1:0]  i_rd_data_a,
    input  logic [cdq_pkg::DATA_W-1:0]  i_rd_data_b
);
    import cdq_pkg::*;

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int SW    = CW + 1;
    localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [CFG_W-1:0]  r_cap_raw;
    logic              r_acc, n_acc;
    logic              r_empty, r_full;

    logic [CMP_W-1:0]  cap_cmp;
    logic [CW-1:0]     cap;
    logic              cur_empty, cur_full;
    logic              cmd_fire, cfg_fire;
    logic [SW-1:0]     back_sum, next_sum, rear_sum;
    logic [AW-1:0]     back_idx, next_idx, rear_idx;

    // Effective capacity: zero reads as one, large values saturate.
    always_comb begin
        cap_cmp = CMP_W'(r_cap_raw);
        if (r_cap_raw == '0) begin
            cap_cmp = CMP_W'(1);
        end else if (cap_cmp > CMP_W'(CAPACITY)) begin
            cap_cmp = CMP_W'(CAPACITY);
        end
        cap = CW'(cap_cmp);
    end

    assign cur_empty = (r_count == '0);
    assign cur_full  = (r_count >= cap);
    assign cmd_fire  = i_cmd.valid & i_cmd.ready;
    assign cfg_fire  = i_cfg.valid & i_cfg.ready;

    // Index arithmetic with wrap by compare and subtract.
    always_comb begin
        back_sum = SW'(r_head) + SW'(r_count);
        if (back_sum >= SW'(cap)) begin
            back_sum = back_sum - SW'(cap);
        end
        back_idx = AW'(back_sum);

        next_sum = SW'(r_head) + SW'(1);
        if (next_sum >= SW'(cap)) begin
            next_sum = next_sum - SW'(cap);
        end
        next_idx = AW'(next_sum);

        rear_sum = SW'(r_head) + SW'(r_count) - SW'(1);
        if (rear_sum >= SW'(cap)) begin
            rear_sum = rear_sum - SW'(cap);
        end
        rear_idx = AW'(rear_sum);
    end

    // Next state and operation decode.
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_acc     = r_acc;
        o_wr_en   = 1'b0;
        o_wr_addr = back_idx;
        o_wr_data = i_cmd.payload.value;
        o_rd_en   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (cmd_fire) begin
                    n_state = ST_READ;
                    n_acc   = 1'b0;
                    unique case (i_cmd.payload.op)
                        OP_PUSH_FRONT: begin
                            if (!cur_full) begin
                                n_head    = (r_head == '0) ? AW'(cap - CW'(1))
                                                           : r_head - AW'(1);
                                n_count   = r_count + CW'(1);
                                o_wr_en   = 1'b1;
                                o_wr_addr = n_head;
                                n_acc     = 1'b1;
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (!cur_full) begin
                                n_count   = r_count + CW'(1);
                                o_wr_en   = 1'b1;
                                o_wr_addr = back_idx;
                                n_acc     = 1'b1;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (!cur_empty) begin
                                n_count = r_count - CW'(1);
                                n_head  = next_idx;
                                n_acc   = 1'b1;
                            end
                        end
                        OP_POP_BACK: begin
                            if (!cur_empty) begin
                                n_count = r_count - CW'(1);
                                n_acc   = 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            n_acc = 1'b1;
                        end
                        default: begin
                            n_acc = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ: begin
                o_rd_en = 1'b1;
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers; a capacity write also empties the deque.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_cap_raw <= CAP_RESET;
            r_acc     <= 1'b0;
            r_empty   <= 1'b1;
            r_full    <= 1'b0;
        end else if (cfg_fire) begin
            r_cap_raw <= i_cfg.payload;
            r_head    <= '0;
            r_count   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_acc   <= n_acc;
            if (cmd_fire) begin
                r_empty <= (n_count == '0);
                r_full  <= (n_count >= cap);
            end
        end
    end

    // Ring reads of the front and rear entries after the operation.
    assign o_rd_addr_a = r_head;
    assign o_rd_addr_b = rear_idx;

    // Handshakes and response beat; a pending capacity write goes first.
    assign i_cmd.ready = (r_state == ST_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = (r_state == ST_RESP);

    always_comb begin
        o_rsp.payload.accepted    = r_acc;
        o_rsp.payload.front_value = r_empty ? '1 : i_rd_data_a;
        o_rsp.payload.rear_value  = r_empty ? '1 : i_rd_data_b;
        o_rsp.payload.is_empty    = r_empty;
        o_rsp.payload.is_full     = r_full;
    end

    // The count never exceeds the effective capacity.
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cap)
        else $error("entry count above capacity");

    // The head always points inside the ring in use.
    a_head_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SW'(r_head) < SW'(cap)))
        else $error("head index outside ring");

    // The ring is written only on an accepted command beat.
    a_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> cmd_fire)
        else $error("ring write without a command beat");

    // An accepted command is followed by the read cycle.
    a_read_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_fire && !cfg_fire) |=> (r_state == ST_READ))
        else $error("missing read cycle after command");

endmodule

[src/circular_deque.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue in a ring memory
// Flow: a command beat moves the sequencer to ST_READ, where the ring is read,
// then to ST_RESP, where the response beat is valid; a new command is taken
// only back in ST_IDLE, after the response beat has been taken.
// Reset: head and count go to zero, the capacity register to 16; the ring
// contents are not cleared.
// ----------------------------------------------------------------------------
module circular_deque #(
    parameter int CAPACITY = cdq_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdq_cmd_if.sink     i_cmd,
    cdq_rsp_if.source   o_rsp,
    cdq_cfg_if.sink     i_cfg
);
    import cdq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr_a;
    logic [AW-1:0]     rd_addr_b;
    logic [DATA_W-1:0] rd_data_a;
    logic [DATA_W-1:0] rd_data_b;

    // Sequencer and index arithmetic.
    cdq_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_rsp       (o_rsp),
        .i_cfg       (i_cfg),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b),
        .i_rd_data_a (rd_data_a),
        .i_rd_data_b (rd_data_b)
    );

    // Ring entry storage.
    cdq_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_en     (rd_en),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

endmodule

[tb/cdq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_checker: response scoreboard of the circular deque
// Watches the command, response and capacity channels, keeps its own copy
// of the ring, head and count, predicts one response per command beat and
// compares every response beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module cdq_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cdq_cmd_if    i_cmd,
    cdq_rsp_if    i_rsp,
    cdq_cfg_if    i_cfg,
    output int    o_err_count,
    output int    o_outstanding
);
    import cdq_pkg::*;

    // Shadow state of the deque.
    logic [DATA_W-1:0] slot_mem [CAPACITY_DEF];
    logic [CFG_W-1:0]  cap_reg;
    int                front_idx;
    int                fill_cnt;

    // Responses predicted but not yet seen, oldest first.
    t_rsp pending_rsp [$];

    // Capacity actually in force: zero acts as one, large values saturate.
    function automatic int ring_limit();
        if (cap_reg == '0) begin
            return 1;
        end
        if (int'(cap_reg) > CAPACITY_DEF) begin
            return CAPACITY_DEF;
        end
        return int'(cap_reg);
    endfunction

    // Slot of the back entry; valid only while the deque holds entries.
    function automatic int back_slot(input int lim);
        int idx;
        idx = front_idx + fill_cnt - 1;
        if (idx >= lim) begin
            idx -= lim;
        end
        return idx;
    endfunction

    // Apply one command to the shadow state and return the response it causes.
    function automatic t_rsp deque_apply(input logic [OP_W-1:0] op,
                                         input logic [DATA_W-1:0] val);
        int   lim;
        t_rsp rsp;
        logic acc;
        lim = ring_limit();
        acc = 1'b0;
        case (op)
            OP_PUSH_FRONT: begin
                if (fill_cnt < lim) begin
                    front_idx = (front_idx == 0) ? lim - 1 : front_idx - 1;
                    fill_cnt++;
                    slot_mem[front_idx] = val;
                    acc = 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (fill_cnt < lim) begin
                    fill_cnt++;
                    slot_mem[back_slot(lim)] = val;
                    acc = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (fill_cnt != 0) begin
                    fill_cnt--;
                    front_idx++;
                    if (front_idx >= lim) begin
                        front_idx -= lim;
                    end
                    acc = 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (fill_cnt != 0) begin
                    fill_cnt--;
                    acc = 1'b1;
                end
            end
            OP_QUERY: begin
                acc = 1'b1;
            end
            default: begin
                // Unused codes report the state like a query but are refused.
                acc = 1'b0;
            end
        endcase

        rsp.accepted    = acc;
        rsp.is_empty    = (fill_cnt == 0);
        rsp.is_full     = (fill_cnt >= lim);
        rsp.front_value = rsp.is_empty ? -32'sd1 : $signed(slot_mem[front_idx]);
        rsp.rear_value  = rsp.is_empty ? -32'sd1 : $signed(slot_mem[back_slot(lim)]);
        return rsp;
    endfunction

    // Report one field that differs from its prediction.
    task automatic compare_field(input string name, input logic [DATA_W-1:0] exp_val,
                                 input logic [DATA_W-1:0] act_val);
        if (act_val !== exp_val) begin
            o_err_count++;
            $display("%0t: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
                     $time, name, $signed(exp_val), exp_val, $signed(act_val), act_val);
        end
    endtask

    // Sample all channels at the rising edge; check responses before new
    // predictions are queued so a beat never matches its own command.
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            cap_reg   = CAP_RESET;
            front_idx = 0;
            fill_cnt  = 0;
            pending_rsp.delete();
        end else begin
            // A capacity write also empties the deque.
            if (i_cfg.valid && i_cfg.ready) begin
                cap_reg   = i_cfg.payload;
                front_idx = 0;
                fill_cnt  = 0;
            end

            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_rsp.size() == 0) begin
                    o_err_count++;
                    $display("%0t: response beat with none expected, actual %p",
                             $time, i_rsp.payload);
                end else begin
                    exp_rsp = pending_rsp.pop_front();
                    compare_field("accepted", DATA_W'(exp_rsp.accepted),
                                  DATA_W'(i_rsp.payload.accepted));
                    compare_field("front_value", exp_rsp.front_value,
                                  i_rsp.payload.front_value);
                    compare_field("rear_value", exp_rsp.rear_value,
                                  i_rsp.payload.rear_value);
                    compare_field("is_empty", DATA_W'(exp_rsp.is_empty),
                                  DATA_W'(i_rsp.payload.is_empty));
                    compare_field("is_full", DATA_W'(exp_rsp.is_full),
                                  DATA_W'(i_rsp.payload.is_full));
                end
            end

            if (i_cmd.valid && i_cmd.ready) begin
                pending_rsp.push_back(deque_apply(i_cmd.payload.op, i_cmd.payload.value));
            end
        end
        o_outstanding = pending_rsp.size();
    end

endmodule

[tb/circular_deque_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_tb: stimulus and verdict for the circular deque
// Drives a directed pass over empty, full, wrap and refused operations, then
// random phases at many capacities (zero and saturating values included)
// biased to fill and drain the ring. Both sides idle at random; the checker
// beside the block scores every response beat.
// ----------------------------------------------------------------------------
module circular_deque_tb;
    import cdq_pkg::*;

    localparam int LIMIT_CYCLES = 500_000;
    localparam int N_PHASES     = 12;
    localparam int PHASE_BEATS  = 120;
    localparam int CHUNK_BEATS  = 20;
    localparam int SETTLE_CYC   = 4;

    // Codes outside the defined operations.
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    // Traffic mix of one chunk of random commands.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    logic clk;
    logic rst_n;
    int   err_count;
    int   outstanding;
    int   cycle_cnt;
    int   ready_hold;
    bit   no_idle;

    cdq_cmd_if cmd_ch ();
    cdq_rsp_if rsp_ch ();
    cdq_cfg_if cfg_ch ();

    circular_deque u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    cdq_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cmd         (cmd_ch),
        .i_rsp         (rsp_ch),
        .i_cfg         (cfg_ch),
        .o_err_count   (err_count),
        .o_outstanding (outstanding)
    );

    // Clock.
    initial begin
        clk = 1'b0;
    end
    always #1 clk = ~clk;

    // Run limit.
    initial begin
        cycle_cnt = 0;
    end
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Response back-pressure: bursts of ready, short and long stalls, and
    // occasional long stretches that never stall.
    always @(negedge clk) begin
        int r;
        if (rst_n) begin
            if (ready_hold > 0) begin
                ready_hold--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    rsp_ch.ready = 1'b1;
                    ready_hold   = $urandom_range(0, 7);
                end else if (r < 90) begin
                    rsp_ch.ready = 1'b0;
                    ready_hold   = $urandom_range(0, 2);
                end else if (r < 95) begin
                    rsp_ch.ready = 1'b0;
                    ready_hold   = $urandom_range(7, 39);
                end else begin
                    rsp_ch.ready = 1'b1;
                    ready_hold   = $urandom_range(30, 80);
                end
            end
        end
    end

    // Value to insert: mostly random, sometimes an extreme.
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    // Operation for the given traffic mix.
    function automatic logic [OP_W-1:0] pick_op(input t_mix mix);
        int r;
        int ins_pct;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            return OP_QUERY;
        end
        if (r < 9) begin
            return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        case (mix)
            MIX_FILL:  ins_pct = 75;
            MIX_DRAIN: ins_pct = 25;
            default:   ins_pct = 50;
        endcase
        if ($urandom_range(0, 99) < ins_pct) begin
            return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end
        return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    endfunction

    // Send one command beat; called and left at a falling edge. Valid stays
    // high between back-to-back beats.
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
        int gap;
        gap = no_idle ? 0 : idle_len();
        if (gap > 0) begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid         = 1'b1;
        cmd_ch.payload.op    = op;
        cmd_ch.payload.value = val;
        @(posedge clk);
        while (!cmd_ch.ready) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Write the capacity register once every response is back.
    task automatic write_cap(input logic [CFG_W-1:0] cap);
        cmd_ch.valid = 1'b0;
        while (outstanding != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYC) @(negedge clk);
        cfg_ch.valid   = 1'b1;
        cfg_ch.payload = cap;
        @(posedge clk);
        while (!cfg_ch.ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Main sequence.
    initial begin
        logic [CFG_W-1:0] cap_sel;
        t_mix             mix;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        ready_hold     = 0;
        no_idle        = 1'b0;
        mix            = MIX_EVEN;
        rst_n          = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset capacity: refused deletes and unused codes on an empty
        // deque, a front insert that wraps the head, extreme values.
        send_cmd(OP_QUERY, 32'h1234_5678);
        send_cmd(OP_POP_FRONT, 32'hFFFF_FFFF);
        send_cmd(OP_POP_BACK, 32'h0);
        send_cmd(OP_UNUSED_LO, 32'hDEAD_BEEF);
        send_cmd(OP_UNUSED_HI, 32'h0);
        send_cmd(OP_PUSH_FRONT, 32'h7FFF_FFFF);
        send_cmd(OP_PUSH_BACK, 32'h8000_0000);
        send_cmd(OP_PUSH_FRONT, 32'h0);
        send_cmd(OP_PUSH_BACK, 32'hFFFF_FFFF);
        send_cmd(OP_PUSH_BACK, 32'hAAAA_AAAA);
        send_cmd(OP_PUSH_FRONT, 32'h5555_5555);
        send_cmd(OP_UNUSED_HI - 3'd1, 32'h0F0F_0F0F);
        send_cmd(OP_POP_FRONT, 32'h0);
        send_cmd(OP_POP_BACK, 32'h0);
        send_cmd(OP_POP_FRONT, 32'h0);

        // Capacity of one: full after a single insert, both ends refused.
        write_cap(CFG_W'(1));
        send_cmd(OP_PUSH_BACK, 32'h1);
        send_cmd(OP_PUSH_FRONT, 32'h2);
        send_cmd(OP_PUSH_BACK, 32'h3);
        send_cmd(OP_QUERY, 32'h0);
        send_cmd(OP_POP_FRONT, 32'h0);
        send_cmd(OP_POP_BACK, 32'h0);
        send_cmd(OP_PUSH_FRONT, 32'hFFFF_FFFB);
        send_cmd(OP_POP_BACK, 32'h0);

        // Random phases: fixed extremes first, then random capacities.
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       cap_sel = CAP_RESET;
                1:       cap_sel = '0;
                2:       cap_sel = '1;
                3:       cap_sel = CFG_W'(CAPACITY_DEF + 1);
                4:       cap_sel = CFG_W'(2);
                5:       cap_sel = CFG_W'(CAPACITY_DEF - 1);
                default: cap_sel = CFG_W'($urandom_range(0, 31));
            endcase
            write_cap(cap_sel);
            for (int k = 0; k < PHASE_BEATS; k++) begin
                if (k % CHUNK_BEATS == 0) begin
                    mix     = t_mix'($urandom_range(0, 2));
                    no_idle = ($urandom_range(0, 4) == 0);
                end
                send_cmd(pick_op(mix), pick_value());
            end
        end

        // Drain and verdict.
        cmd_ch.valid = 1'b0;
        while (outstanding != 0) begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
        if (err_count == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
src/cdq_pkg.sv
src/cdq_if.sv
src/cdq_ram.sv
src/cdq_ctrl.sv
src/circular_deque.sv
tb/cdq_checker.sv
tb/circular_deque_tb.sv
